FILE: rtl/lkvc_pkg.sv
// Shared types and constants for the LRU key-value cache.
package lkvc_pkg;

	localparam int DATA_W    = 32;
	localparam int IN_KEY_W  = 32;
	localparam int KEY_EXT_W = 64;
	localparam int CFG_W     = 5;

	localparam logic [CFG_W-1:0]  LIMIT_RESET = 5'd16;
	localparam logic              OP_GET      = 1'b0;
	localparam logic              OP_PUT      = 1'b1;
	localparam logic [DATA_W-1:0] RD_MISS     = 32'hFFFF_FFFF;
	localparam logic [DATA_W-1:0] RD_PUT      = 32'h0000_0000;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SCAN,
		ST_DRAIN,
		ST_DECIDE,
		ST_UPDATE,
		ST_UPD_DRAIN,
		ST_DONE
	} lkvc_state_t;

endpackage

FILE: rtl/lkvc_ram.sv
// Generic simple dual-port RAM, one write and one registered read port.
module lkvc_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16
) (
	input  logic                                   clk,
	input  logic                                   we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                       wdata,
	input  logic                                   re,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                       rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

FILE: rtl/lru_key_value_cache.sv
// Top level: fully associative key-value cache with LRU replacement.
//
//   channel   signals                                   dir  payload
//   request   req_valid / req_stall                     in   opcode, lookup_key, write_value
//   response  rsp_valid / rsp_stall                     out  found, read_data, evicted
//   config    cfg_we / cfg_wdata                        in   entry limit
//
// One request at a time. A request scans all ENTRIES keys through the key RAM; a hit or
// an insert then rewrites all ranks in a second RAM pass, which a get miss skips.
// Reset clears valid bits and occupancy and sets the limit to 16; RAMs need no clear.
// A stalled response is held in the output register while the next request runs.
module lru_key_value_cache
	import lkvc_pkg::*;
#(
	parameter int ENTRIES  = 16,
	parameter int KEY_BITS = 32
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       req_valid,
	output logic                       req_stall,
	input  logic                       opcode,
	input  logic signed [IN_KEY_W-1:0] lookup_key,
	input  logic signed [DATA_W-1:0]   write_value,
	output logic                       rsp_valid,
	input  logic                       rsp_stall,
	output logic                       found,
	output logic signed [DATA_W-1:0]   read_data,
	output logic                       evicted,
	input  logic                       cfg_we,
	input  logic [CFG_W-1:0]           cfg_wdata
);

	localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
	localparam int CNT_W = $clog2(ENTRIES + 1);
	localparam int LIM_W = (CNT_W > CFG_W) ? CNT_W : CFG_W;
	localparam int MW    = KEY_BITS + IDX_W;
	localparam logic [IDX_W-1:0] LAST = IDX_W'(ENTRIES - 1);

	lkvc_state_t state_q, state_d;

	logic [IDX_W-1:0]    cnt_q;
	logic                rd_vld_s1, upd_s1;
	logic [IDX_W-1:0]    rd_idx_s1;
	logic [ENTRIES-1:0]  valid_q;
	logic [CNT_W-1:0]    occ_q;
	logic [CFG_W-1:0]    limit_q;

	logic                op_q;
	logic [KEY_BITS-1:0] key_q;
	logic [DATA_W-1:0]   val_q;

	logic                hit_q, lru_any_q, free_any_q, ins_q, evict_q;
	logic [IDX_W-1:0]    hit_idx_q, hit_rank_q, lru_idx_q, lru_rank_q, free_idx_q, tgt_q;

	logic                rsp_valid_q, found_q, evicted_q;
	logic [DATA_W-1:0]   read_data_q;

	logic [KEY_EXT_W-1:0] key_ext;
	logic [LIM_W-1:0]     lim_ext, eff_lim;
	logic                 do_evict, have_slot, insert;
	logic [IDX_W-1:0]     slot;

	logic                meta_re, meta_we;
	logic [IDX_W-1:0]    meta_raddr, meta_waddr;
	logic [MW-1:0]       meta_wdata, meta_rdata;
	logic                val_re, val_we;
	logic [IDX_W-1:0]    val_raddr, val_waddr;
	logic [DATA_W-1:0]   val_rdata;

	logic [KEY_BITS-1:0] rd_key;
	logic [IDX_W-1:0]    rd_rank;
	logic                rd_v;
	logic                req_acc, rsp_load;

	// key is sign-extended, then the low KEY_BITS are kept
	assign key_ext = {{(KEY_EXT_W - IN_KEY_W){lookup_key[IN_KEY_W-1]}}, lookup_key};
	assign req_acc = req_valid && !req_stall;
	assign rd_key  = meta_rdata[MW-1:IDX_W];
	assign rd_rank = meta_rdata[IDX_W-1:0];
	assign rd_v    = valid_q[rd_idx_s1];

	lkvc_ram #(.WIDTH(MW), .DEPTH(ENTRIES)) u_meta_ram (
		.clk   (clk),
		.we    (meta_we),
		.waddr (meta_waddr),
		.wdata (meta_wdata),
		.re    (meta_re),
		.raddr (meta_raddr),
		.rdata (meta_rdata)
	);

	lkvc_ram #(.WIDTH(DATA_W), .DEPTH(ENTRIES)) u_val_ram (
		.clk   (clk),
		.we    (val_we),
		.waddr (val_waddr),
		.wdata (val_q),
		.re    (val_re),
		.raddr (val_raddr),
		.rdata (val_rdata)
	);

	// replacement decision, valid during ST_DECIDE
	always_comb begin
		lim_ext = LIM_W'(limit_q);
		if (lim_ext == '0) begin
			eff_lim = LIM_W'(1);
		end else if (lim_ext > LIM_W'(ENTRIES)) begin
			eff_lim = LIM_W'(ENTRIES);
		end else begin
			eff_lim = lim_ext;
		end
		insert    = (op_q == OP_PUT) && !hit_q;
		do_evict  = insert && (LIM_W'(occ_q) >= eff_lim) && lru_any_q;
		have_slot = free_any_q || do_evict;
		if (do_evict && (!free_any_q || (lru_idx_q < free_idx_q))) begin
			slot = lru_idx_q;
		end else begin
			slot = free_idx_q;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (req_valid) state_d = ST_SCAN;
			end
			ST_SCAN: begin
				if (cnt_q == LAST) state_d = ST_DRAIN;
			end
			ST_DRAIN: state_d = ST_DECIDE;
			ST_DECIDE: begin
				state_d = (hit_q || (insert && have_slot)) ? ST_UPDATE : ST_DONE;
			end
			ST_UPDATE: begin
				if (cnt_q == LAST) state_d = ST_UPD_DRAIN;
			end
			ST_UPD_DRAIN: state_d = ST_DONE;
			ST_DONE: begin
				if (!rsp_valid_q || !rsp_stall) state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		req_stall  = (state_q != ST_IDLE);
		rsp_load   = (state_q == ST_DONE) && (!rsp_valid_q || !rsp_stall);
		meta_re    = (state_q == ST_SCAN) || (state_q == ST_UPDATE);
		meta_raddr = cnt_q;
		meta_we    = rd_vld_s1 && upd_s1;
		meta_waddr = rd_idx_s1;
		meta_wdata = meta_rdata;
		if (rd_idx_s1 == tgt_q) begin
			meta_wdata = {(ins_q ? key_q : rd_key), {IDX_W{1'b0}}};
		end else if (rd_v && (ins_q || (rd_rank < hit_rank_q))) begin
			meta_wdata = {rd_key, rd_rank + IDX_W'(1)};
		end
		val_re    = (state_q == ST_DECIDE) && (op_q == OP_GET) && hit_q;
		val_raddr = hit_idx_q;
		val_we    = (state_q == ST_DECIDE) && (op_q == OP_PUT) && (hit_q || have_slot);
		val_waddr = hit_q ? hit_idx_q : slot;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			cnt_q       <= '0;
			rd_vld_s1   <= 1'b0;
			upd_s1      <= 1'b0;
			valid_q     <= '0;
			occ_q       <= '0;
			limit_q     <= LIMIT_RESET;
			hit_q       <= 1'b0;
			lru_any_q   <= 1'b0;
			free_any_q  <= 1'b0;
			ins_q       <= 1'b0;
			evict_q     <= 1'b0;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q   <= state_d;
			rd_vld_s1 <= meta_re;
			upd_s1    <= (state_q == ST_UPDATE);
			cnt_q     <= meta_re ? (cnt_q + IDX_W'(1)) : '0;
			if (cfg_we) limit_q <= cfg_wdata;

			if (req_acc) begin
				hit_q      <= 1'b0;
				lru_any_q  <= 1'b0;
				free_any_q <= 1'b0;
			end else if (rd_vld_s1 && !upd_s1) begin
				if (rd_v && (rd_key == key_q) && !hit_q) hit_q <= 1'b1;
				if (rd_v && (!lru_any_q || (rd_rank > lru_rank_q))) lru_any_q <= 1'b1;
				if (!rd_v) free_any_q <= 1'b1;
			end

			if (state_q == ST_DECIDE) begin
				ins_q   <= insert && have_slot;
				evict_q <= do_evict;
				if (insert && have_slot) begin
					valid_q          <= (valid_q & ~(ENTRIES'(do_evict) << lru_idx_q))
						| (ENTRIES'(1) << slot);
					occ_q <= occ_q + CNT_W'(1) - CNT_W'(do_evict);
				end
			end

			if (rsp_load) begin
				rsp_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		rd_idx_s1 <= cnt_q;
		if (req_acc) begin
			op_q  <= opcode;
			key_q <= key_ext[KEY_BITS-1:0];
			val_q <= write_value;
		end
		if (rd_vld_s1 && !upd_s1) begin
			if (rd_v && (rd_key == key_q) && !hit_q) begin
				hit_idx_q  <= rd_idx_s1;
				hit_rank_q <= rd_rank;
			end
			if (rd_v && (!lru_any_q || (rd_rank > lru_rank_q))) begin
				lru_idx_q  <= rd_idx_s1;
				lru_rank_q <= rd_rank;
			end
			if (!rd_v && !free_any_q) free_idx_q <= rd_idx_s1;
		end
		if (state_q == ST_DECIDE) begin
			tgt_q <= hit_q ? hit_idx_q : slot;
		end
		if (rsp_load) begin
			found_q   <= hit_q;
			evicted_q <= evict_q && (op_q == OP_PUT) && !hit_q;
			if (op_q == OP_GET) begin
				read_data_q <= hit_q ? val_rdata : RD_MISS;
			end else begin
				read_data_q <= RD_PUT;
			end
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign found     = found_q;
	assign read_data = read_data_q;
	assign evicted   = evicted_q;

endmodule

FILE: rtl/lkvc_checker.sv
// Port-level checker for the LRU key-value cache, bound to the top level.
module lkvc_checker
	import lkvc_pkg::*;
(
	input logic              clk,
	input logic              arst_n,
	input logic              req_valid,
	input logic              req_stall,
	input logic              rsp_valid,
	input logic              rsp_stall,
	input logic              found,
	input logic [DATA_W-1:0] read_data,
	input logic              evicted
);

	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_stall |=> rsp_valid && $stable(read_data) && $stable(found)
			&& $stable(evicted))
		else $error("stalled response changed");

	a_evict_put_miss: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && evicted |-> !found && (read_data == RD_PUT))
		else $error("eviction on a response that is not a put miss");

	a_miss_data: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !found |-> (read_data == RD_PUT) || (read_data == RD_MISS))
		else $error("miss response carries data");

	a_busy_after_req: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && !req_stall |=> req_stall && !$rose(rsp_valid))
		else $error("request not held busy");

endmodule

bind lru_key_value_cache lkvc_checker u_lkvc_checker (.*);

FILE: bench/tb_lru_key_value_cache.sv
`timescale 1ns / 100ps
// Testbench for lru_key_value_cache: get/put requests checked against a shadow LRU model.
module tb_lru_key_value_cache;
	import lkvc_pkg::*;

	localparam int NUM_ENTRIES = 16;
	localparam int RSP_LATENCY = 2 * NUM_ENTRIES + 5;
	localparam int POOL_MAX    = 24;

	typedef struct packed {
		logic              found;
		logic [DATA_W-1:0] read_data;
		logic              evicted;
	} cache_rsp_t;

	logic                       clk;
	logic                       arst_n;
	logic                       req_valid;
	logic                       req_stall;
	logic                       opcode;
	logic signed [IN_KEY_W-1:0] lookup_key;
	logic signed [DATA_W-1:0]   write_value;
	logic                       rsp_valid;
	logic                       rsp_stall;
	logic                       found;
	logic signed [DATA_W-1:0]   read_data;
	logic                       evicted;
	logic                       cfg_we;
	logic [CFG_W-1:0]           cfg_wdata;

	logic                shadow_valid [NUM_ENTRIES];
	logic [IN_KEY_W-1:0] shadow_key   [NUM_ENTRIES];
	logic [DATA_W-1:0]   shadow_value [NUM_ENTRIES];
	int                  shadow_rank  [NUM_ENTRIES];
	int                  shadow_count;
	int                  shadow_limit;

	cache_rsp_t pending_rsp [$];
	int         err_count;
	bit         src_idle_on;
	bit         sink_idle_on;

	lru_key_value_cache u_dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.req_valid  (req_valid),
		.req_stall  (req_stall),
		.opcode     (opcode),
		.lookup_key (lookup_key),
		.write_value(write_value),
		.rsp_valid  (rsp_valid),
		.rsp_stall  (rsp_stall),
		.found      (found),
		.read_data  (read_data),
		.evicted    (evicted),
		.cfg_we     (cfg_we),
		.cfg_wdata  (cfg_wdata)
	);

	always #2 clk = ~clk;

	initial begin
		#2_000_000;
		$display("DONE: errors detected");
		$finish;
	end

	task automatic note_error(string msg);
		err_count++;
		if (err_count <= 10) begin
			$display("%0t ERROR: %s", $time, msg);
		end
	endtask

	function automatic int effective_limit();
		if (shadow_limit == 0) return 1;
		if (shadow_limit > NUM_ENTRIES) return NUM_ENTRIES;
		return shadow_limit;
	endfunction

	function automatic void promote_entry(int idx);
		int old_rank;
		old_rank = shadow_rank[idx];
		for (int i = 0; i < NUM_ENTRIES; i++) begin
			if (shadow_valid[i] && shadow_rank[i] < old_rank) shadow_rank[i]++;
		end
		shadow_rank[idx] = 0;
	endfunction

	function automatic cache_rsp_t cache_access(logic op, logic [IN_KEY_W-1:0] key,
			logic [DATA_W-1:0] value);
		cache_rsp_t rsp;
		int         hit_idx;
		int         lru_idx;
		int         slot;
		rsp.read_data = RD_PUT;
		rsp.evicted   = 1'b0;
		hit_idx       = -1;
		for (int i = 0; i < NUM_ENTRIES; i++) begin
			if (hit_idx < 0 && shadow_valid[i] && shadow_key[i] == key) hit_idx = i;
		end
		rsp.found = (hit_idx >= 0);
		if (op == OP_GET) begin
			if (hit_idx >= 0) begin
				rsp.read_data = shadow_value[hit_idx];
				promote_entry(hit_idx);
			end else begin
				rsp.read_data = RD_MISS;
			end
		end else if (hit_idx >= 0) begin
			shadow_value[hit_idx] = value;
			promote_entry(hit_idx);
		end else begin
			if (shadow_count >= effective_limit()) begin
				lru_idx = -1;
				for (int i = 0; i < NUM_ENTRIES; i++) begin
					if (shadow_valid[i] && (lru_idx < 0 || shadow_rank[i] > shadow_rank[lru_idx]))
						lru_idx = i;
				end
				if (lru_idx >= 0) begin
					shadow_valid[lru_idx] = 1'b0;
					shadow_rank[lru_idx]  = 0;
					shadow_count--;
					rsp.evicted = 1'b1;
				end
			end
			slot = -1;
			for (int i = 0; i < NUM_ENTRIES; i++) begin
				if (!shadow_valid[i]) begin
					if (slot < 0) slot = i;
				end else begin
					shadow_rank[i]++;
				end
			end
			if (slot >= 0) begin
				shadow_valid[slot] = 1'b1;
				shadow_key[slot]   = key;
				shadow_value[slot] = value;
				shadow_rank[slot]  = 0;
				shadow_count++;
			end
		end
		return rsp;
	endfunction

	task automatic send_request(logic op, logic [IN_KEY_W-1:0] key, logic [DATA_W-1:0] value);
		int gap;
		gap = src_idle_on ? $urandom_range(0, 15) : 0;
		if (gap > 0) begin
			req_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req_valid   <= 1'b1;
		opcode      <= op;
		lookup_key  <= key;
		write_value <= value;
		@(posedge clk);
		while (req_stall) @(posedge clk);
		pending_rsp.push_back(cache_access(op, key, value));
	endtask

	task automatic wait_drain();
		req_valid <= 1'b0;
		while (pending_rsp.size() != 0) @(posedge clk);
	endtask

	task automatic set_entry_limit(int value);
		wait_drain();
		@(posedge clk);
		cfg_we    <= 1'b1;
		cfg_wdata <= value[CFG_W-1:0];
		@(posedge clk);
		cfg_we       <= 1'b0;
		shadow_limit = value;
	endtask

	// runs at the reset limit
	task automatic test_get_put_extremes();
		src_idle_on  = 1'b1;
		sink_idle_on = 1'b1;
		send_request(OP_GET, 32'h0000_0000, 32'h1234_5678);
		send_request(OP_PUT, 32'h8000_0000, 32'h7FFF_FFFF);
		send_request(OP_PUT, 32'h7FFF_FFFF, 32'h8000_0000);
		send_request(OP_PUT, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
		send_request(OP_PUT, 32'h0000_0000, 32'h0000_0000);
		send_request(OP_GET, 32'h8000_0000, 32'h0000_0000);
		send_request(OP_GET, 32'h7FFF_FFFF, 32'hFFFF_FFFF);
		send_request(OP_GET, 32'hFFFF_FFFF, 32'h0000_0000);
		send_request(OP_GET, 32'h0000_0000, 32'hFFFF_FFFF);
		send_request(OP_PUT, 32'h7FFF_FFFF, 32'h0000_0001);
		send_request(OP_GET, 32'h7FFF_FFFF, 32'h0000_0000);
		send_request(OP_GET, 32'h0000_0005, 32'h0000_0000);
	endtask

	// limit below occupancy, zero limit, limit beyond entry count
	task automatic test_limit_edges();
		set_entry_limit(2);
		send_request(OP_PUT, 32'd10, 32'hA0A0_A0A0);
		send_request(OP_PUT, 32'd11, 32'hB1B1_B1B1);
		send_request(OP_GET, 32'd10, 32'h0000_0000);
		send_request(OP_PUT, 32'd12, 32'hC2C2_C2C2);
		send_request(OP_GET, 32'd11, 32'h0000_0000);
		send_request(OP_GET, 32'd10, 32'h0000_0000);
		set_entry_limit(0);
		send_request(OP_PUT, 32'd13, 32'hD3D3_D3D3);
		send_request(OP_GET, 32'd13, 32'h0000_0000);
		set_entry_limit(31);
		send_request(OP_PUT, 32'd14, 32'hE4E4_E4E4);
		send_request(OP_GET, 32'd12, 32'h0000_0000);
	endtask

	task automatic run_random_phase(int limit, int n_items);
		logic [IN_KEY_W-1:0] key_pool [POOL_MAX];
		logic [IN_KEY_W-1:0] key;
		logic                op;
		int                  pool_size;
		set_entry_limit(limit);
		src_idle_on  = ($urandom_range(0, 3) != 0);
		sink_idle_on = ($urandom_range(0, 3) != 0);
		pool_size = effective_limit() + $urandom_range(1, 8);
		if (pool_size > POOL_MAX) pool_size = POOL_MAX;
		for (int i = 0; i < pool_size; i++) key_pool[i] = $urandom;
		repeat (n_items) begin
			op  = 1'($urandom_range(0, 1));
			key = ($urandom_range(0, 9) == 0) ? $urandom : key_pool[$urandom_range(0, pool_size - 1)];
			send_request(op, key, $urandom);
		end
	endtask

	task automatic test_random_traffic();
		run_random_phase(16, 100);
		run_random_phase(3, 100);
		run_random_phase(1, 100);
		run_random_phase(0, 100);
		run_random_phase(31, 100);
		run_random_phase(8, 100);
		run_random_phase($urandom_range(1, 16), 100);
	endtask

	initial begin
		cache_rsp_t exp_rsp;
		cache_rsp_t got_rsp;
		int         stall_left;
		rsp_stall  = 1'b0;
		stall_left = 0;
		forever begin
			@(posedge clk);
			if (arst_n && rsp_valid && !rsp_stall) begin
				if (pending_rsp.size() == 0) begin
					note_error("response with no request outstanding");
				end else begin
					exp_rsp = pending_rsp.pop_front();
					got_rsp = '{found, read_data, evicted};
					if (got_rsp !== exp_rsp) begin
						note_error($sformatf(
							"exp found=%0b data=%h evicted=%0b, got found=%0b data=%h evicted=%0b",
							exp_rsp.found, exp_rsp.read_data, exp_rsp.evicted,
							got_rsp.found, got_rsp.read_data, got_rsp.evicted));
					end
				end
				stall_left = sink_idle_on ? $urandom_range(0, 15) : 0;
			end
			if (rsp_valid && stall_left > 0) begin
				rsp_stall <= 1'b1;
				stall_left--;
			end else begin
				rsp_stall <= 1'b0;
			end
		end
	end

	initial begin
		clk          = 1'b0;
		arst_n       = 1'b0;
		req_valid    = 1'b0;
		opcode       = OP_GET;
		lookup_key   = '0;
		write_value  = '0;
		cfg_we       = 1'b0;
		cfg_wdata    = LIMIT_RESET;
		err_count    = 0;
		src_idle_on  = 1'b1;
		sink_idle_on = 1'b1;
		shadow_count = 0;
		shadow_limit = LIMIT_RESET;
		for (int i = 0; i < NUM_ENTRIES; i++) begin
			shadow_valid[i] = 1'b0;
			shadow_key[i]   = '0;
			shadow_value[i] = '0;
			shadow_rank[i]  = 0;
		end
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_get_put_extremes();
		test_limit_edges();
		test_random_traffic();
		wait_drain();
		repeat (RSP_LATENCY) @(posedge clk);
		if (err_count == 0 && pending_rsp.size() == 0) begin
			$display("DONE: 0 errors");
		end else begin
			$display("DONE: errors detected");
		end
		$finish;
	end

endmodule

FILE: files.f
rtl/lkvc_pkg.sv
rtl/lkvc_ram.sv
rtl/lru_key_value_cache.sv
rtl/lkvc_checker.sv
bench/tb_lru_key_value_cache.sv
